FILE: rtl/core/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the SLIP response deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

  localparam int MaxFrameBytes = 1024;
  localparam int HeaderBytes   = 8;
  localparam int CntW          = $clog2(MaxFrameBytes + 1);
  localparam int OutLenW       = 11;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;
  localparam logic [7:0] DirResp    = 8'h01;

  localparam logic [7:0] ReadRegCmdReset = 8'd10;

  localparam int EvqDepth = 4;
  localparam int EvqPtrW  = $clog2(EvqDepth);
  localparam int ResDepth = 2;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_ARM     = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_CLOSE = 2'd1,
    EV_ARM   = 2'd2,
    EV_CLEAR = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_ACCEPTED  = 2'd1,
    MODE_REJECTED  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    FS_OK           = 3'd0,
    FS_BAD_DIR      = 3'd1,
    FS_BAD_ESCAPE   = 3'd2,
    FS_TOO_SHORT    = 3'd3,
    FS_LEN_MISMATCH = 3'd4,
    FS_TOO_LONG     = 3'd5
  } fstat_e;

  typedef enum logic {
    RES_BYTE    = 1'b0,
    RES_SUMMARY = 1'b1
  } res_kind_e;

  // Event passed from the front to the back. The flag marks an escape error
  // on a byte, or a dangling escape on a close.
  typedef struct packed {
    ev_kind_e   kind;
    logic [7:0] data;
    logic       flag;
  } ev_t;

  typedef struct packed {
    res_kind_e          kind;
    logic [7:0]         data_byte;
    logic [7:0]         command;
    logic [15:0]        payload_size;
    logic [31:0]        reg_value;
    logic [7:0]         dev_status;
    logic [7:0]         dev_error;
    logic [OutLenW-1:0] decoded_length;
    fstat_e             frame_status;
  } res_t;

  // Handshake between the event queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } evq_stat_t;

endpackage

FILE: rtl/core/sld_front.sv
// ---------------------------------------------------------------------------
// sld_front
// Accepts input items, hunts for the first delimiter, unescapes SLIP bytes
// and turns each item into at most one event for the back end.
// ---------------------------------------------------------------------------
module sld_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [1:0]    op_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    expect_cmd_i,
  output logic          ev_valid_o,
  output sld_pkg::ev_t  ev_o
);

  logic hunt_q, hunt_d;
  logic escp_q, escp_d;

  always_comb begin
    hunt_d     = hunt_q;
    escp_d     = escp_q;
    ev_valid_o = 1'b0;
    ev_o       = '0;
    if (accept_i) begin
      case (sld_pkg::op_e'(op_i))
        sld_pkg::OP_ARM: begin
          escp_d     = 1'b0;
          ev_valid_o = 1'b1;
          ev_o.kind  = sld_pkg::EV_ARM;
          ev_o.data  = expect_cmd_i;
        end
        sld_pkg::OP_RESTART: begin
          hunt_d     = 1'b1;
          escp_d     = 1'b0;
          ev_valid_o = 1'b1;
          ev_o.kind  = sld_pkg::EV_CLEAR;
        end
        sld_pkg::OP_BYTE: begin
          if (hunt_q) begin
            // The frame state is already clear while hunting.
            if (rx_byte_i == sld_pkg::SlipEnd) begin
              hunt_d = 1'b0;
            end
          end else if (rx_byte_i == sld_pkg::SlipEnd) begin
            escp_d     = 1'b0;
            ev_valid_o = 1'b1;
            ev_o.kind  = sld_pkg::EV_CLOSE;
            ev_o.flag  = escp_q;
          end else if (escp_q) begin
            escp_d     = 1'b0;
            ev_valid_o = 1'b1;
            ev_o.kind  = sld_pkg::EV_BYTE;
            ev_o.data  = (rx_byte_i == sld_pkg::SlipEscEnd) ? sld_pkg::SlipEnd
                                                            : sld_pkg::SlipEsc;
            ev_o.flag  = (rx_byte_i != sld_pkg::SlipEscEnd) &&
                         (rx_byte_i != sld_pkg::SlipEscEsc);
          end else if (rx_byte_i == sld_pkg::SlipEsc) begin
            escp_d = 1'b1;
          end else begin
            ev_valid_o = 1'b1;
            ev_o.kind  = sld_pkg::EV_BYTE;
            ev_o.data  = rx_byte_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q <= 1'b1;
      escp_q <= 1'b0;
    end else begin
      hunt_q <= hunt_d;
      escp_q <= escp_d;
    end
  end

endmodule

FILE: rtl/core/sld_evq.sv
// ---------------------------------------------------------------------------
// sld_evq
// Short event queue between the front and the back end.
// ---------------------------------------------------------------------------
module sld_evq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sld_pkg::ev_t       push_ev_i,
  input  logic               pop_i,
  output sld_pkg::ev_t       head_ev_o,
  output sld_pkg::evq_stat_t stat_o
);

  localparam int CntBits = $clog2(sld_pkg::EvqDepth + 1);

  sld_pkg::ev_t mem_q [sld_pkg::EvqDepth];
  logic [sld_pkg::EvqPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]          cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntBits'(sld_pkg::EvqDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_ev_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntBits'(do_push) - CntBits'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/core/sld_back.sv
// ---------------------------------------------------------------------------
// sld_back
// Frame tracker: counts decoded bytes, decides acceptance, collects the
// header and tail fields and queues payload and summary results.
// ---------------------------------------------------------------------------
module sld_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          ev_valid_i,
  input  sld_pkg::ev_t  ev_i,
  output logic          ev_pop_o,
  input  logic          res_pop_i,
  output logic          res_empty_o,
  output sld_pkg::res_t res_o
);

  localparam int CW = sld_pkg::CntW;

  logic [7:0]          rrc_q;
  logic                armed_q, armed_d;
  logic [7:0]          exp_q, exp_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  sld_pkg::mode_e      mode_q, mode_d;
  logic                dir_q, dir_d;
  logic                eerr_q, eerr_d;
  logic [15:0]         hsize_q, hsize_d;
  logic [31:0]         hval_q, hval_d;
  logic [7:0]          tail_q [4];
  logic [7:0]          tail_d [4];

  sld_pkg::res_t       rmem_q [sld_pkg::ResDepth];
  logic                rwr_q, rrd_q;
  logic [1:0]          rcnt_q, rcnt_d;
  logic                res_push, res_do_pop, res_space;
  sld_pkg::res_t       res_new;
  logic                eerr_c;
  logic [16:0]         need_len;
  sld_pkg::fstat_e     fstat;

  assign res_space   = (rcnt_q != 2'(sld_pkg::ResDepth));
  assign ev_pop_o    = ev_valid_i && res_space;
  assign res_empty_o = (rcnt_q == '0);
  assign res_do_pop  = res_pop_i && !res_empty_o;
  assign res_o       = rmem_q[rrd_q];
  assign need_len    = {1'b0, hsize_q} + 17'(sld_pkg::HeaderBytes);
  assign eerr_c      = eerr_q || ev_i.flag;

  always_comb begin
    if (!dir_q) begin
      fstat = sld_pkg::FS_BAD_DIR;
    end else if (eerr_c) begin
      fstat = sld_pkg::FS_BAD_ESCAPE;
    end else if (cnt_q >= CW'(sld_pkg::MaxFrameBytes)) begin
      fstat = sld_pkg::FS_TOO_LONG;
    end else if (cnt_q < CW'(sld_pkg::HeaderBytes)) begin
      fstat = sld_pkg::FS_TOO_SHORT;
    end else if (17'(cnt_q) != need_len) begin
      fstat = sld_pkg::FS_LEN_MISMATCH;
    end else begin
      fstat = sld_pkg::FS_OK;
    end
  end

  always_comb begin
    armed_d  = armed_q;
    exp_d    = exp_q;
    cnt_d    = cnt_q;
    mode_d   = mode_q;
    dir_d    = dir_q;
    eerr_d   = eerr_q;
    hsize_d  = hsize_q;
    hval_d   = hval_q;
    tail_d   = tail_q;
    res_push = 1'b0;
    res_new  = '0;
    if (ev_pop_o) begin
      case (ev_i.kind)
        sld_pkg::EV_BYTE: begin
          eerr_d = eerr_c;
          // Bytes that arrive at the saturated count are dropped.
          if (cnt_q < CW'(sld_pkg::MaxFrameBytes)) begin
            if (cnt_q == CW'(0)) begin
              dir_d = (ev_i.data == sld_pkg::DirResp);
            end else if (cnt_q == CW'(1)) begin
              if (armed_q && ev_i.data == exp_q) begin
                mode_d  = sld_pkg::MODE_ACCEPTED;
                armed_d = 1'b0;
              end else begin
                mode_d = sld_pkg::MODE_REJECTED;
              end
            end else if (cnt_q < CW'(4)) begin
              if (cnt_q[0]) hsize_d[15:8] = ev_i.data;
              else          hsize_d[7:0]  = ev_i.data;
            end else if (cnt_q < CW'(sld_pkg::HeaderBytes)) begin
              case (cnt_q[1:0])
                2'd0:    hval_d[7:0]   = ev_i.data;
                2'd1:    hval_d[15:8]  = ev_i.data;
                2'd2:    hval_d[23:16] = ev_i.data;
                default: hval_d[31:24] = ev_i.data;
              endcase
            end
            tail_d[3] = tail_q[2];
            tail_d[2] = tail_q[1];
            tail_d[1] = tail_q[0];
            tail_d[0] = ev_i.data;
            cnt_d     = cnt_q + 1'b1;
            if (mode_d == sld_pkg::MODE_ACCEPTED && cnt_q >= CW'(2)) begin
              res_push          = 1'b1;
              res_new.kind      = sld_pkg::RES_BYTE;
              res_new.data_byte = ev_i.data;
            end
          end
        end
        sld_pkg::EV_CLOSE: begin
          if (mode_q == sld_pkg::MODE_ACCEPTED) begin
            res_push               = 1'b1;
            res_new.kind           = sld_pkg::RES_SUMMARY;
            res_new.command        = exp_q;
            res_new.payload_size   = hsize_q;
            res_new.reg_value      = (exp_q == rrc_q) ? hval_q : 32'd0;
            res_new.dev_status     = tail_q[3];
            res_new.dev_error      = tail_q[2];
            res_new.decoded_length = sld_pkg::OutLenW'(cnt_q);
            res_new.frame_status   = fstat;
          end
        end
        sld_pkg::EV_ARM: begin
          armed_d = 1'b1;
          exp_d   = ev_i.data;
        end
        default: begin
        end
      endcase
      // Every event but a byte ends or abandons the current frame.
      if (ev_i.kind != sld_pkg::EV_BYTE) begin
        cnt_d   = '0;
        mode_d  = sld_pkg::MODE_UNDECIDED;
        dir_d   = 1'b0;
        eerr_d  = 1'b0;
        hsize_d = '0;
        hval_d  = '0;
        for (int i = 0; i < 4; i++) tail_d[i] = '0;
      end
    end
    rcnt_d = rcnt_q + 2'(res_push) - 2'(res_do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rmem_q[rwr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rrc_q   <= sld_pkg::ReadRegCmdReset;
      armed_q <= 1'b0;
      exp_q   <= '0;
      cnt_q   <= '0;
      mode_q  <= sld_pkg::MODE_UNDECIDED;
      dir_q   <= 1'b0;
      eerr_q  <= 1'b0;
      hsize_q <= '0;
      hval_q  <= '0;
      for (int i = 0; i < 4; i++) tail_q[i] <= '0;
      rwr_q   <= 1'b0;
      rrd_q   <= 1'b0;
      rcnt_q  <= '0;
    end else begin
      if (cfg_we_i) rrc_q <= cfg_data_i;
      armed_q <= armed_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
      dir_q   <= dir_d;
      eerr_q  <= eerr_d;
      hsize_q <= hsize_d;
      hval_q  <= hval_d;
      tail_q  <= tail_d;
      if (res_push)   rwr_q <= ~rwr_q;
      if (res_do_pop) rrd_q <= ~rrd_q;
      rcnt_q  <= rcnt_d;
    end
  end

endmodule

FILE: rtl/core/slip_response_deframer_core.sv
// ---------------------------------------------------------------------------
// slip_response_deframer_core
// SLIP response deframer for a ROM-loader link.
// ---------------------------------------------------------------------------
// Input items enter through push/full: a received byte, an arm event with
// the expected command, or a restart that hunts for the next delimiter.
// Results leave through empty/pop, oldest first: the decoded bytes of an
// accepted frame past its command byte, then one summary item at its close.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes the
// read-register command code; it is always ready.
// Throughput is one input item per cycle while full is low. The front end
// unescapes a byte in the cycle it is accepted and writes an event into a
// four-entry queue; the back end takes one event per cycle from that queue
// into a two-entry result buffer while it has space; each item passes
// through both in turn. When the receiver stops popping, the result buffer
// and then the event queue fill; full rises when it holds four events.
// Reset empties both queues, clears the frame state, disarms the block,
// sets the register to 10 and starts hunting for a delimiter.
// ---------------------------------------------------------------------------
module slip_response_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  expect_cmd_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  command_o,
  output logic [15:0] payload_size_o,
  output logic [31:0] reg_value_o,
  output logic [7:0]  dev_status_o,
  output logic [7:0]  dev_error_o,
  output logic [10:0] decoded_length_o,
  output logic [2:0]  frame_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic               accept;
  logic               fr_ev_valid;
  sld_pkg::ev_t       fr_ev;
  sld_pkg::ev_t       head_ev;
  sld_pkg::evq_stat_t evq_stat;
  logic               ev_pop;
  sld_pkg::res_t      res;

  assign cfg_ready_o = 1'b1;
  assign full        = evq_stat.full;
  assign accept      = push && !evq_stat.full;

  sld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .expect_cmd_i (expect_cmd_i),
    .ev_valid_o   (fr_ev_valid),
    .ev_o         (fr_ev)
  );

  sld_evq u_evq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (fr_ev_valid),
    .push_ev_i (fr_ev),
    .pop_i     (ev_pop),
    .head_ev_o (head_ev),
    .stat_o    (evq_stat)
  );

  sld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ev_valid_i  (!evq_stat.empty),
    .ev_i        (head_ev),
    .ev_pop_o    (ev_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign data_byte_o      = res.data_byte;
  assign command_o        = res.command;
  assign payload_size_o   = res.payload_size;
  assign reg_value_o      = res.reg_value;
  assign dev_status_o     = res.dev_status;
  assign dev_error_o      = res.dev_error;
  assign decoded_length_o = res.decoded_length;
  assign frame_status_o   = res.frame_status;

endmodule

FILE: rtl/core/sld_checker.sv
// ---------------------------------------------------------------------------
// sld_checker
// Port-level checks of the SLIP response deframer, bound to the top level.
// ---------------------------------------------------------------------------
module sld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        kind_o,
  input logic [7:0]  data_byte_o,
  input logic [7:0]  command_o,
  input logic [15:0] payload_size_o,
  input logic [31:0] reg_value_o,
  input logic [10:0] decoded_length_o,
  input logic [2:0]  frame_status_o
);

  // The registers clear asynchronously when reset falls, so the queue shows
  // empty throughout reset.
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty during reset");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(data_byte_o)
                          && $stable(frame_status_o)))
    else $error("waiting result changed while stalled");

  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == sld_pkg::RES_BYTE) |->
      (command_o == 8'd0 && decoded_length_o == 11'd0 &&
       frame_status_o == sld_pkg::FS_OK && reg_value_o == 32'd0))
    else $error("payload byte item carries summary fields");

  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == sld_pkg::RES_SUMMARY && frame_status_o == sld_pkg::FS_OK)
      |-> (data_byte_o == 8'd0 &&
           17'(decoded_length_o) == {1'b0, payload_size_o} + 17'(sld_pkg::HeaderBytes)))
    else $error("ok summary with inconsistent length");

endmodule

bind slip_response_deframer_core sld_checker u_sld_checker (.*);
